>>> hdl/assert_macros.svh
// Assertion macros shared by the compressor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of i_clk, with reset low masking it.
`define FFAC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("compressor check failed");

// Checks that a condition in one cycle is followed by another in the next cycle.
`define FFAC_ASSERT_NEXT(lbl, pre, post) \
    `FFAC_ASSERT(lbl, (pre) |=> (post))

`endif

>>> hdl/ffac_pkg.sv
// Shared constants, types, tables and helper functions of the audio compressor.
`timescale 1ns / 1ps

package ffac_pkg;

    localparam int SAMPLE_WIDTH     = 24;
    localparam int TABLE_INDEX_BITS = 8;
    localparam int TABLE_SIZE       = 1 << TABLE_INDEX_BITS;
    localparam int NORM_W           = SAMPLE_WIDTH + TABLE_INDEX_BITS;
    localparam int POS_W            = $clog2(SAMPLE_WIDTH);
    localparam int MUL_W            = 33;
    localparam int PROD_W           = 2 * MUL_W;
    localparam int GAIN_W           = 17;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 17;

    // Q8.8 dB limits: -144 dB floor and the saturation range of the gain.
    localparam logic signed [GAIN_W-1:0] DB_FLOOR = 17'h17000;
    localparam logic signed [GAIN_W-1:0] GAIN_MAX = 17'h0FFFF;
    localparam logic signed [GAIN_W-1:0] GAIN_MIN = 17'h10000;

    // Scale factors between log2 (Q.16) and dB (Q8.8).
    localparam logic signed [MUL_W-1:0] LOG2_TO_DB = 33'sd394566;
    localparam logic signed [MUL_W-1:0] DB_TO_LOG2 = 33'sd2786635;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_INV_RATIO = 3'd1,
        CFG_ATTACK    = 3'd2,
        CFG_RELEASE   = 3'd3,
        CFG_MAKEUP    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic en;
        logic acc;
    } t_mul_ctl;

    typedef struct packed {
        logic                        done;
        logic [POS_W-1:0]            pos;
        logic [TABLE_INDEX_BITS-1:0] idx;
    } t_norm_stat;

    typedef logic [TABLE_SIZE-1:0][15:0] t_log_tab;
    typedef logic [TABLE_SIZE-1:0][31:0] t_exp_tab;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        int          j;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        x = v;
        for (j = 0; j < 32; j++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2(1 + i/TABLE_SIZE) in Q.16 by repeated squaring.
    function automatic t_log_tab build_log_tab();
        t_log_tab    t;
        logic [63:0] m;
        logic [15:0] acc;
        int          i;
        int          k;
        for (i = 0; i < TABLE_SIZE; i++) begin
            m   = 64'(TABLE_SIZE + i) << (30 - TABLE_INDEX_BITS);
            acc = '0;
            for (k = 0; k < 16; k++) begin
                m   = (m * m) >> 30;
                acc = acc << 1;
                if (m >= 64'h8000_0000) begin
                    m      = m >> 1;
                    acc[0] = 1'b1;
                end
            end
            t[i] = acc;
        end
        return t;
    endfunction

    // 2^(i/TABLE_SIZE) in Q2.30 as a product of repeated square roots of two.
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    t;
        logic [63:0] roots [TABLE_INDEX_BITS+1];
        logic [63:0] e;
        int          i;
        int          k;
        roots[0] = 64'h8000_0000;
        for (k = 1; k <= TABLE_INDEX_BITS; k++) begin
            roots[k] = isqrt64(roots[k-1] << 30);
        end
        for (i = 0; i < TABLE_SIZE; i++) begin
            e = 64'h4000_0000;
            for (k = 0; k < TABLE_INDEX_BITS; k++) begin
                if (((i >> k) & 1) != 0) begin
                    e = (e * roots[TABLE_INDEX_BITS-k]) >> 30;
                end
            end
            t[i] = e[31:0];
        end
        return t;
    endfunction

    localparam t_log_tab LOG_TAB = build_log_tab();
    localparam t_exp_tab EXP_TAB = build_exp_tab();

    function automatic logic signed [GAIN_W-1:0] sat_gain(input logic signed [23:0] v);
        logic signed [GAIN_W-1:0] r;
        if (v > 24'(GAIN_MAX)) begin
            r = GAIN_MAX;
        end else if (v < 24'(GAIN_MIN)) begin
            r = GAIN_MIN;
        end else begin
            r = v[GAIN_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/ffac_norm.sv
// Leading-one normalizer that shifts the sample magnitude one bit per cycle.
`timescale 1ns / 1ps

module ffac_norm import ffac_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_start,
    input  logic [SAMPLE_WIDTH-1:0] i_mag,
    output t_norm_stat              o_stat
);

    logic [NORM_W-1:0] r_norm;
    logic [NORM_W-1:0] n_norm;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;

    always_comb begin
        n_norm = r_norm;
        n_pos  = r_pos;
        if (i_start) begin
            n_norm = {i_mag, {TABLE_INDEX_BITS{1'b0}}};
            n_pos  = POS_W'(SAMPLE_WIDTH - 1);
        end else if (!r_norm[NORM_W-1]) begin
            n_norm = r_norm << 1;
            n_pos  = r_pos - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_norm <= n_norm;
        r_pos  <= n_pos;
    end

    // The bits right below the leading one form the log table index.
    assign o_stat.done = r_norm[NORM_W-1];
    assign o_stat.pos  = r_pos;
    assign o_stat.idx  = r_norm[NORM_W-2 -: TABLE_INDEX_BITS];

endmodule

>>> hdl/ffac_mul.sv
// Shared signed multiplier with a registered product and optional accumulate.
`timescale 1ns / 1ps

module ffac_mul import ffac_pkg::*; (
    input  logic                     i_clk,
    input  t_mul_ctl                 i_ctl,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] w_mul;

    assign w_mul  = i_a * i_b;
    assign n_prod = i_ctl.acc ? r_prod + w_mul : w_mul;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

>>> hdl/feed_forward_audio_compressor.sv
// Top level of the feed-forward log-domain audio compressor.
`timescale 1ns / 1ps
//
//  Channel   Signals                                      Direction
//  input     i_in_valid, o_in_ready, i_sample_in          into the block
//  output    o_out_valid, i_out_ready, o_sample_out       out of the block
//  config    i_cfg_we, i_cfg_idx, i_cfg_data              write only, no wait
//
//  Each sample is normalized one bit per cycle until the leading one of its magnitude
//  reaches the top (a zero sample leaves at once), then steps through the sequencer
//  states that share the single multiplier before its result is loaded. A new
//  sample is taken only in the idle state, in the cycle after the result is loaded.
//  Reset is synchronous and active low; it restores the register defaults and
//  clears the smoothed gain to 0 dB. A stalled output holds the sequencer in its
//  last state, while a finished result waiting in the output register does not
//  keep the next sample from being taken.
`include "assert_macros.svh"

module feed_forward_audio_compressor import ffac_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data
);

    // One-hot sequencer: each state issues at most one multiply, whose product
    // is consumed by the following state.
    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_NORM   = 12'b0000_0000_0010,
        S_LEVEL  = 12'b0000_0000_0100,
        S_CURVE  = 12'b0000_0000_1000,
        S_GR     = 12'b0000_0001_0000,
        S_SM1    = 12'b0000_0010_0000,
        S_SM2    = 12'b0000_0100_0000,
        S_SM3    = 12'b0000_1000_0000,
        S_TOT    = 12'b0001_0000_0000,
        S_EXPIDX = 12'b0010_0000_0000,
        S_APPLY  = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration registers.
    logic signed [GAIN_W-1:0] r_threshold;
    logic [15:0]              r_inv_ratio;
    logic [15:0]              r_attack;
    logic [15:0]              r_release;
    logic [12:0]              r_makeup;

    // Per-sample working registers.
    logic [SAMPLE_WIDTH-1:0]     r_mag;
    logic                        r_neg;
    logic                        r_zero;
    logic signed [GAIN_W-1:0]    r_level;
    logic signed [GAIN_W-1:0]    r_gr;
    logic signed [GAIN_W-1:0]    r_smooth;
    logic signed [9:0]           r_e;
    logic [TABLE_INDEX_BITS-1:0] r_idx;

    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_sample_out;

    logic                     w_in_accept;
    logic                     w_load_out;
    logic [SAMPLE_WIDTH-1:0]  w_mag;
    t_norm_stat               w_norm;
    t_mul_ctl                 w_mul_ctl;
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;

    logic signed [MUL_W-1:0]  w_l2_log;
    logic signed [17:0]       w_level_wide;
    logic signed [17:0]       w_diff;
    logic signed [23:0]       w_gr_wide;
    logic [15:0]              w_coef;
    logic [16:0]              w_one_minus;
    logic signed [17:0]       w_tot;
    logic signed [25:0]       w_l2_exp;

    logic signed [10:0]       w_sh;
    logic [10:0]              w_lsh;
    logic [63:0]              w_p;
    logic [63:0]              w_shr;
    logic [63:0]              w_shl;
    logic [SAMPLE_WIDTH-1:0]  w_lim;
    logic [SAMPLE_WIDTH-1:0]  w_res;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_load_out  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign w_mag       = i_sample_in[SAMPLE_WIDTH-1] ? (~i_sample_in + 1'b1) : i_sample_in;

    ffac_norm u_norm (
        .i_clk   (i_clk),
        .i_start (w_in_accept),
        .i_mag   (w_mag),
        .o_stat  (w_norm)
    );

    ffac_mul u_mul (
        .i_clk  (i_clk),
        .i_ctl  (w_mul_ctl),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 17'h1F600;
            r_inv_ratio <= 16'd10923;
            r_attack    <= 16'd65530;
            r_release   <= 16'd65506;
            r_makeup    <= 13'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_INV_RATIO: r_inv_ratio <= i_cfg_data[15:0];
                CFG_ATTACK:    r_attack    <= i_cfg_data[15:0];
                CFG_RELEASE:   r_release   <= i_cfg_data[15:0];
                CFG_MAKEUP:    r_makeup    <= i_cfg_data[12:0];
                default:       ;
            endcase
        end
    end

    // Level in log2 Q.16: exponent from the leading-one position plus the
    // fractional part from the log table.
    assign w_l2_log = $signed((MUL_W'(w_norm.pos) - MUL_W'(SAMPLE_WIDTH - 1)) << 16)
                    + $signed(MUL_W'(LOG_TAB[w_norm.idx]));
    assign w_level_wide = $signed(w_prod[24 +: 18]);
    assign w_diff       = $signed({r_level[GAIN_W-1], r_level})
                        - $signed({r_threshold[GAIN_W-1], r_threshold});
    // Curve output minus level: the excess scaled by the inverse ratio, less the excess.
    assign w_gr_wide    = $signed(w_prod[15 +: 24]) - 24'(w_diff);
    // Attack applies while the reduction deepens, release otherwise.
    assign w_coef       = (r_gr < r_smooth) ? r_attack : r_release;
    assign w_one_minus  = 17'h10000 - 17'(w_coef);
    assign w_tot        = $signed({r_smooth[GAIN_W-1], r_smooth}) + $signed({5'b0, r_makeup});
    assign w_l2_exp     = $signed(w_prod[16 +: 26]);

    // Multiplier operands by state.
    always_comb begin
        w_mul_ctl = '0;
        w_mul_a   = '0;
        w_mul_b   = '0;
        unique case (r_state)
            S_NORM: begin
                w_mul_ctl.en = 1'b1;
                w_mul_a      = w_l2_log;
                w_mul_b      = LOG2_TO_DB;
            end
            S_CURVE: begin
                w_mul_ctl.en = 1'b1;
                w_mul_a      = MUL_W'(w_diff);
                w_mul_b      = $signed(MUL_W'(r_inv_ratio));
            end
            S_SM1: begin
                w_mul_ctl.en = 1'b1;
                w_mul_a      = $signed(MUL_W'(w_one_minus));
                w_mul_b      = MUL_W'(r_gr);
            end
            S_SM2: begin
                w_mul_ctl.en  = 1'b1;
                w_mul_ctl.acc = 1'b1;
                w_mul_a       = $signed(MUL_W'(w_coef));
                w_mul_b       = MUL_W'(r_smooth);
            end
            S_TOT: begin
                w_mul_ctl.en = 1'b1;
                w_mul_a      = MUL_W'(w_tot);
                w_mul_b      = DB_TO_LOG2;
            end
            S_APPLY: begin
                w_mul_ctl.en = 1'b1;
                w_mul_a      = $signed(MUL_W'(r_mag));
                w_mul_b      = $signed(MUL_W'(EXP_TAB[r_idx]));
            end
            default: ;
        endcase
    end

    // Final scaling by 2^(e-30) with saturation to the signed sample range.
    assign w_p   = w_prod[63:0];
    assign w_sh  = 11'sd30 - 11'(r_e);
    assign w_lsh = 11'(-w_sh);
    assign w_lim = r_neg ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    assign w_shr = w_p >> w_sh[5:0];
    assign w_shl = w_p << w_lsh[5:0];

    always_comb begin
        if (w_sh >= 11'sd64) begin
            w_res = '0;
        end else if (w_sh >= 11'sd0) begin
            w_res = (w_shr > 64'(w_lim)) ? w_lim : w_shr[SAMPLE_WIDTH-1:0];
        end else if (w_p == '0) begin
            w_res = '0;
        end else if ((w_lsh >= 11'd40) || (w_p > 64'(w_lim >> w_lsh[5:0]))) begin
            w_res = w_lim;
        end else begin
            w_res = (w_shl > 64'(w_lim)) ? w_lim : w_shl[SAMPLE_WIDTH-1:0];
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_accept) n_state = S_NORM;
            S_NORM:   if (r_zero || w_norm.done) n_state = S_LEVEL;
            S_LEVEL:  n_state = S_CURVE;
            S_CURVE:  n_state = S_GR;
            S_GR:     n_state = S_SM1;
            S_SM1:    n_state = S_SM2;
            S_SM2:    n_state = S_SM3;
            S_SM3:    n_state = S_TOT;
            S_TOT:    n_state = S_EXPIDX;
            S_EXPIDX: n_state = S_APPLY;
            S_APPLY:  n_state = S_OUT;
            S_OUT:    if (w_load_out) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_smooth    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SM3) begin
                r_smooth <= sat_gain($signed(w_prod[16 +: 24]));
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_mag  <= w_mag;
            r_neg  <= i_sample_in[SAMPLE_WIDTH-1];
            r_zero <= (w_mag == '0);
        end
        if (r_state == S_LEVEL) begin
            if (r_zero || (w_level_wide < DB_FLOOR)) begin
                r_level <= DB_FLOOR;
            end else begin
                r_level <= w_level_wide[GAIN_W-1:0];
            end
        end
        if (r_state == S_GR) begin
            r_gr <= (r_level < r_threshold) ? '0 : sat_gain(w_gr_wide);
        end
        if (r_state == S_EXPIDX) begin
            r_e   <= w_l2_exp[25:16];
            r_idx <= w_l2_exp[15 -: TABLE_INDEX_BITS];
        end
        if (w_load_out) begin
            r_sample_out <= r_neg ? $signed(~w_res + 1'b1) : $signed(w_res);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

    `FFAC_ASSERT_NEXT(a_accept_starts, w_in_accept, r_state == S_NORM)
    `FFAC_ASSERT_NEXT(a_stall_holds, (r_state == S_OUT) && r_out_valid && !i_out_ready, r_state == S_OUT)
    `FFAC_ASSERT_NEXT(a_load_valid, w_load_out, o_out_valid && (r_state == S_IDLE))

endmodule
